// ===== rtl/apm_pkg.sv =====
package apm_pkg;

	// field and register widths
	localparam int SAMPLE_W   = 12;
	localparam int CFG_W      = 13;
	localparam int PAGE_LEN_W = 13;
	localparam int REF_W      = 13;
	localparam int FS_W       = 12;
	localparam int MV_W       = 16;
	localparam int PROD_W     = REF_W + SAMPLE_W;
	localparam int STEP_W     = 5;
	localparam int CFG_IDX_W  = 2;

	// converter resolution actually used from the sample field
	localparam int SAMPLE_BITS = 12;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
		SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

	localparam int MAX_PAGE_LENGTH_DEF = 4096;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PAGE_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_MV = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd2;

	// register reset values
	localparam logic [PAGE_LEN_W-1:0] PAGE_LENGTH_RST = PAGE_LEN_W'(256);
	localparam logic [REF_W-1:0] REFERENCE_MV_RST = REF_W'(3300);
	localparam logic [FS_W-1:0] FULL_SCALE_RST = FS_W'(4095);

	// quotient bits produced per division
	localparam logic [STEP_W-1:0] AVG_STEPS = STEP_W'(SAMPLE_W);
	localparam logic [STEP_W-1:0] MV_STEPS = STEP_W'(MV_W);

	localparam logic [MV_W-1:0] MV_SAT = '1;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                page_tag;
	} in_item_t;

	typedef struct packed {
		logic                page_tag_out;
		logic [SAMPLE_W-1:0] min_raw;
		logic [SAMPLE_W-1:0] max_raw;
		logic [SAMPLE_W-1:0] avg_raw;
		logic [MV_W-1:0]     millivolts;
	} out_item_t;

	typedef struct packed {
		logic add;
		logic clear;
	} acc_ctrl_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} div_cmd_t;

endpackage

// ===== rtl/apm_accum.sv =====
module apm_accum #(
	parameter int MAX_PAGE_LENGTH = apm_pkg::MAX_PAGE_LENGTH_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  apm_pkg::acc_ctrl_t                        ctrl,
	input  logic [apm_pkg::SAMPLE_W-1:0]              sample,
	input  logic [apm_pkg::FS_W-1:0]                  full_scale,
	output logic [apm_pkg::SAMPLE_W+$clog2(MAX_PAGE_LENGTH+1)-1:0] sum,
	output logic [apm_pkg::SAMPLE_W-1:0]              min_val,
	output logic [apm_pkg::SAMPLE_W-1:0]              max_val,
	output logic [$clog2(MAX_PAGE_LENGTH+1)-1:0]      count
);

	localparam int CNT_W = $clog2(MAX_PAGE_LENGTH + 1);
	localparam int SUM_W = apm_pkg::SAMPLE_W + CNT_W;

	logic [SUM_W-1:0]             sum_q;
	logic [apm_pkg::SAMPLE_W-1:0] min_q;
	logic [apm_pkg::SAMPLE_W-1:0] max_q;
	logic [CNT_W-1:0]             count_q;
	logic [apm_pkg::SAMPLE_W-1:0] fs_ext;

	assign fs_ext = apm_pkg::SAMPLE_W'(full_scale);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.clear) begin
			count_q <= '0;
		end else if (ctrl.add) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// first sample of a page reloads the accumulators
	always_ff @(posedge clk) begin
		if (ctrl.add) begin
			if (count_q == '0) begin
				sum_q <= SUM_W'(sample);
				min_q <= (sample < fs_ext) ? sample : fs_ext;
				max_q <= sample;
			end else begin
				sum_q <= sum_q + SUM_W'(sample);
				if (sample < min_q) begin
					min_q <= sample;
				end
				if (sample > max_q) begin
					max_q <= sample;
				end
			end
		end
	end

	assign sum     = sum_q;
	assign min_val = min_q;
	assign max_val = max_q;
	assign count   = count_q;

endmodule

// ===== rtl/apm_div.sv =====
module apm_div #(
	parameter int DIV_W = 13
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  apm_pkg::div_cmd_t            cmd,
	input  logic [DIV_W-1:0]             rem_init,
	input  logic [apm_pkg::MV_W-1:0]     low,
	input  logic [DIV_W-1:0]             divisor,
	output logic                         done,
	output logic [apm_pkg::MV_W-1:0]     quot
);

	localparam int MV_W = apm_pkg::MV_W;

	logic                       busy_q;
	logic                       done_q;
	logic [apm_pkg::STEP_W-1:0] cnt_q;
	logic [DIV_W-1:0]           rem_q;
	logic [MV_W-1:0]            low_q;
	logic [DIV_W-1:0]           div_q;
	logic [MV_W-1:0]            quot_q;

	logic [DIV_W:0] trial;
	logic [DIV_W:0] diff;
	logic           fits;

	// one restoring step: shift in next dividend bit, compare, subtract
	assign trial = {rem_q, low_q[MV_W-1]};
	assign fits  = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - apm_pkg::STEP_W'(1);
				if (cnt_q == apm_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q  <= rem_init;
			low_q  <= low;
			div_q  <= divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			low_q  <= {low_q[MV_W-2:0], 1'b0};
			quot_q <= {quot_q[MV_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== rtl/adc_page_min_max_average_unit.sv =====
// ADC page statistics.
// Input channel (in_valid / in_stall / in_item): one converter sample with its
// page tag per item. The unit stalls its input while it works on an item.
// Output channel (out_valid / out_stall / out_item): one item per closed page
// with tag, min, max, truncated average and average scaled to millivolts.
// Config: cfg_write / cfg_index / cfg_data; the user must write it only while idle (not enforced).
// Sequence: a sample that does not close its page is accepted, then checked.
// A sample that closes a page goes on through accept, check, the average
// division (12 quotient bits), multiply, saturation check, the millivolt
// division (16 quotient bits) and output load, which waits while the output
// register is held. When the millivolts saturate the second division is skipped.
// Both divisions run one quotient bit per cycle on the same compare/subtract
// unit.
// The result sits in an output register, so a stalled receiver does not hold
// up the next page until a second result is ready to go out.
// Reset: registers return to page length 256, reference 3300 mV, full scale
// 4095; the sample count clears and the output goes empty.
module adc_page_min_max_average_unit #(
	parameter int MAX_PAGE_LENGTH = apm_pkg::MAX_PAGE_LENGTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  apm_pkg::in_item_t               in_item,
	output logic                            out_valid,
	input  logic                            out_stall,
	output apm_pkg::out_item_t              out_item,
	input  logic                            cfg_write,
	input  logic [apm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [apm_pkg::CFG_W-1:0]       cfg_data
);

	localparam int SAMPLE_W = apm_pkg::SAMPLE_W;
	localparam int MV_W     = apm_pkg::MV_W;
	localparam int FS_W     = apm_pkg::FS_W;
	localparam int REF_W    = apm_pkg::REF_W;
	localparam int PROD_W   = apm_pkg::PROD_W;
	localparam int CNT_W    = $clog2(MAX_PAGE_LENGTH + 1);
	localparam int SUM_W    = SAMPLE_W + CNT_W;
	localparam int DIV_W    = (CNT_W > FS_W) ? CNT_W : FS_W;

	// sequencer states
	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_CHECK   = 3'd1;
	localparam logic [2:0] ST_DIV_AVG = 3'd2;
	localparam logic [2:0] ST_MUL     = 3'd3;
	localparam logic [2:0] ST_SAT     = 3'd4;
	localparam logic [2:0] ST_DIV_MV  = 3'd5;
	localparam logic [2:0] ST_OUT     = 3'd6;

	logic [2:0] state_q;

	// configuration
	logic [apm_pkg::PAGE_LEN_W-1:0] page_length_q;
	logic [REF_W-1:0]               reference_q;
	logic [FS_W-1:0]                full_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_length_q <= apm_pkg::PAGE_LENGTH_RST;
			reference_q   <= apm_pkg::REFERENCE_MV_RST;
			full_scale_q  <= apm_pkg::FULL_SCALE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				apm_pkg::REG_PAGE_LENGTH: page_length_q <= cfg_data;
				apm_pkg::REG_REFERENCE_MV: reference_q <= cfg_data;
				apm_pkg::REG_FULL_SCALE: full_scale_q <= cfg_data[FS_W-1:0];
				default: ;
			endcase
		end
	end

	// page length: zero acts as one, clamp to the supported maximum
	logic [CNT_W-1:0] eff_len;

	always_comb begin
		if (page_length_q == '0) begin
			eff_len = CNT_W'(1);
		end else if (32'(page_length_q) > 32'(MAX_PAGE_LENGTH)) begin
			eff_len = CNT_W'(MAX_PAGE_LENGTH);
		end else begin
			eff_len = CNT_W'(page_length_q);
		end
	end

	// accumulators
	logic               in_accept;
	logic               page_done;
	apm_pkg::acc_ctrl_t acc_ctrl;
	logic [SUM_W-1:0]   acc_sum;
	logic [SAMPLE_W-1:0] acc_min;
	logic [SAMPLE_W-1:0] acc_max;
	logic [CNT_W-1:0]   acc_count;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign page_done = (state_q == ST_CHECK) && (acc_count >= eff_len);

	assign acc_ctrl.add   = in_accept;
	assign acc_ctrl.clear = page_done;

	apm_accum #(
		.MAX_PAGE_LENGTH(MAX_PAGE_LENGTH)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (acc_ctrl),
		.sample    (in_item.sample & apm_pkg::SAMPLE_MASK),
		.full_scale(full_scale_q),
		.sum       (acc_sum),
		.min_val   (acc_min),
		.max_val   (acc_max),
		.count     (acc_count)
	);

	// pending result
	logic                tag_q;
	logic [SAMPLE_W-1:0] min_q;
	logic [SAMPLE_W-1:0] max_q;
	logic [SAMPLE_W-1:0] avg_q;
	logic [PROD_W-1:0]   prod_q;
	logic [MV_W-1:0]     mv_q;

	// saturate when quotient would not fit 16 bits; also covers full scale 0
	logic [FS_W+MV_W-1:0] sat_lim;
	logic                 mv_sat;

	assign sat_lim = {full_scale_q, MV_W'(0)};
	assign mv_sat  = (FS_W + MV_W)'(prod_q) >= sat_lim;

	// shared divider, operands chosen by the sequencer
	apm_pkg::div_cmd_t div_cmd;
	logic [DIV_W-1:0]  div_rem_init;
	logic [MV_W-1:0]   div_low;
	logic [DIV_W-1:0]  div_divisor;
	logic              div_done;
	logic [MV_W-1:0]   div_quot;

	always_comb begin
		div_cmd.start = 1'b0;
		div_cmd.steps = apm_pkg::AVG_STEPS;
		div_rem_init  = DIV_W'(acc_sum >> SAMPLE_W);
		div_low       = {acc_sum[SAMPLE_W-1:0], (MV_W - SAMPLE_W)'(0)};
		div_divisor   = DIV_W'(acc_count);
		if (state_q == ST_SAT) begin
			div_cmd.start = !mv_sat;
			div_cmd.steps = apm_pkg::MV_STEPS;
			div_rem_init  = DIV_W'(prod_q >> MV_W);
			div_low       = prod_q[MV_W-1:0];
			div_divisor   = DIV_W'(full_scale_q);
		end else if (page_done) begin
			div_cmd.start = 1'b1;
		end
	end

	apm_div #(
		.DIV_W(DIV_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (div_cmd),
		.rem_init(div_rem_init),
		.low     (div_low),
		.divisor (div_divisor),
		.done    (div_done),
		.quot    (div_quot)
	);

	// output register
	logic               out_valid_q;
	apm_pkg::out_item_t out_q;
	logic               out_free;

	assign out_free = !out_valid_q || !out_stall;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: state_q <= page_done ? ST_DIV_AVG : ST_IDLE;
				ST_DIV_AVG: begin
					if (div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_SAT;
				ST_SAT: state_q <= mv_sat ? ST_OUT : ST_DIV_MV;
				ST_DIV_MV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			tag_q <= in_item.page_tag;
		end
		if (page_done) begin
			min_q <= acc_min;
			max_q <= acc_max;
		end
		if (state_q == ST_DIV_AVG && div_done) begin
			avg_q <= div_quot[SAMPLE_W-1:0];
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(avg_q) * PROD_W'(reference_q);
		end
		if (state_q == ST_SAT && mv_sat) begin
			mv_q <= apm_pkg::MV_SAT;
		end else if (state_q == ST_DIV_MV && div_done) begin
			mv_q <= div_quot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_q.page_tag_out <= tag_q;
			out_q.min_raw      <= min_q;
			out_q.max_raw      <= max_q;
			out_q.avg_raw      <= avg_q;
			out_q.millivolts   <= mv_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef SYNTHESIS
	a_div_done_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV_AVG || state_q == ST_DIV_MV))
		else $error("divider finished outside a division state");

	a_accept_goes_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q == ST_CHECK))
		else $error("accepted sample not followed by page check");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> (acc_count != '0 &&
			32'(acc_count) <= 32'(MAX_PAGE_LENGTH)))
		else $error("sample count out of range at page check");
`endif

endmodule
